>>> src/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg: shared types and codes of the priority ready list
// Holds the input and result word layouts and the operation and error codes.
// ----------------------------------------------------------------------------
package prl_pkg;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_POP     = 2'd1;
  localparam logic [1:0] MODE_REMOVE  = 2'd2;
  localparam logic [1:0] MODE_QUERY   = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_EMPTY    = 2'd1;
  localparam logic [1:0] ERR_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] task_req;
    logic [4:0] level;
  } prl_in_t;

  typedef struct packed {
    logic [5:0] next_task;
    logic [4:0] next_level;
    logic       any_ready;
    logic [1:0] error;
  } prl_out_t;

endpackage

>>> src/prl_fifo.sv
// ----------------------------------------------------------------------------
// prl_fifo: two-entry queue between the front and the back
// Registered word queue with independent valid/ready on each side.
// ----------------------------------------------------------------------------
module prl_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  prl_pkg::prl_in_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output prl_pkg::prl_in_t rd_data
);
  import prl_pkg::*;

  prl_in_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_ready) else $error("queue overflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count step");
`endif

endmodule

>>> src/prl_engine.sv
// ----------------------------------------------------------------------------
// prl_engine: list operations and top-level search
// Sequencer that updates the per-level lists, walks for named removal,
// and finds the highest non-empty level by a leading-one search.
// ----------------------------------------------------------------------------
module prl_engine #(
  parameter int TASKS  = 64,
  parameter int LEVELS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  prl_pkg::prl_in_t  cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output prl_pkg::prl_out_t out_word
);
  import prl_pkg::*;

  localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW = $clog2(TASKS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDN  = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_DROP = 3'd4;
  localparam logic [2:0] S_SRCH = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]        st_r;
  logic [LEVELS-1:0] mask_r;
  logic              hv_r [LEVELS];
  logic [TW-1:0]     hi_r [LEVELS];
  logic              tv_r [LEVELS];
  logic [TW-1:0]     ti_r [LEVELS];
  // link memory: valid bits in flops, indices in an array
  logic [TASKS-1:0]  nv_r;
  logic [TW-1:0]     nmem [TASKS];
  logic [TW-1:0]     nrd_r;

  logic [1:0]        mode_r;
  logic [5:0]        treq_r;
  logic [LW-1:0]     lv_r;
  logic [TW-1:0]     pre_r;
  logic [SW-1:0]     steps_r;
  logic [1:0]        err_r;
  prl_out_t          res_r;
  logic              res_v_r;

  logic              lv_ok, t_ok;
  logic              nw_en;
  logic [TW-1:0]     nw_addr, nw_data, nr_addr;
  logic              nw_v;
  logic [LW-1:0]     top;
  logic              any;

  assign cmd_ready = (st_r == S_IDLE);
  assign out_valid = res_v_r;
  assign out_word  = res_r;

  assign lv_ok = ({27'd0, cmd.level} < 32'(LEVELS));
  assign t_ok  = ({26'd0, cmd.task_req} < 32'(TASKS));

  always_comb begin
    top = '0;
    any = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      if (mask_r[i]) begin
        top = LW'(i);
        any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) nmem[nw_addr] <= nw_data;
    nrd_r <= nmem[nr_addr];
  end

  always_comb begin
    nw_en   = 1'b0;
    nw_addr = treq_r[TW-1:0];
    nw_data = '0;
    nw_v    = 1'b0;
    nr_addr = pre_r;
    if (st_r == S_IDLE && cmd_valid && cmd.mode == MODE_ADD && lv_ok && t_ok) begin
      nw_en   = 1'b1;
      nw_addr = cmd.task_req[TW-1:0];
      nw_data = hi_r[cmd.level[LW-1:0]];
      nw_v    = hv_r[cmd.level[LW-1:0]];
    end else if (st_r == S_IDLE) begin
      nr_addr = (cmd.mode == MODE_REMOVE) ? cmd.task_req[TW-1:0]
                                          : hi_r[cmd.level[LW-1:0]];
    end else if (st_r == S_WALK) begin
      // fetch the named task's link in case this step finds it
      nr_addr = treq_r[TW-1:0];
    end else if (st_r == S_FIX) begin
      // copy the named task's link into its predecessor
      nw_en   = 1'b1;
      nw_addr = pre_r;
      nw_data = nrd_r;
      nw_v    = nv_r[treq_r[TW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      mask_r  <= LEVELS'(1);
      nv_r    <= '0;
      res_v_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        hv_r[i] <= (i == 0);
        tv_r[i] <= (i == 0);
        hi_r[i] <= '0;
        ti_r[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) res_v_r <= 1'b0;
      if (nw_en) nv_r[nw_addr] <= nw_v;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            mode_r  <= cmd.mode;
            treq_r  <= cmd.task_req;
            lv_r    <= cmd.level[LW-1:0];
            steps_r <= '0;
            err_r   <= ERR_OK;
            st_r    <= S_SRCH;
            if (cmd.mode != MODE_QUERY && !lv_ok) begin
              err_r <= ERR_EMPTY;
            end else if (cmd.mode == MODE_ADD) begin
              if (!t_ok) begin
                err_r <= ERR_NOTFOUND;
              end else begin
                if (!hv_r[cmd.level[LW-1:0]]) begin
                  tv_r[cmd.level[LW-1:0]] <= 1'b1;
                  ti_r[cmd.level[LW-1:0]] <= cmd.task_req[TW-1:0];
                  mask_r[cmd.level[LW-1:0]] <= 1'b1;
                end
                hv_r[cmd.level[LW-1:0]] <= 1'b1;
                hi_r[cmd.level[LW-1:0]] <= cmd.task_req[TW-1:0];
              end
            end else if (cmd.mode == MODE_POP || cmd.mode == MODE_REMOVE) begin
              if (!hv_r[cmd.level[LW-1:0]]) begin
                err_r <= ERR_EMPTY;
              end else if (cmd.mode == MODE_REMOVE && !t_ok) begin
                err_r <= ERR_NOTFOUND;
              end else begin
                pre_r <= hi_r[cmd.level[LW-1:0]];
                st_r  <= S_RDN;
              end
            end
          end
        end
        S_RDN: begin
          // nrd_r holds link of head (pop) or of the named task (remove)
          if (mode_r == MODE_POP || pre_r == treq_r[TW-1:0]) begin
            hv_r[lv_r] <= nv_r[pre_r];
            hi_r[lv_r] <= nrd_r;
            nv_r[pre_r] <= 1'b0;
            st_r <= S_DROP;
          end else begin
            st_r <= S_WALK;
          end
        end
        S_WALK: begin
          // nrd_r = link index of pre_r, read from the previous cycle
          if (!nv_r[pre_r] || steps_r >= SW'(TASKS)) begin
            err_r <= ERR_NOTFOUND;
            st_r  <= S_SRCH;
          end else if (nrd_r == treq_r[TW-1:0]) begin
            st_r <= S_FIX;
          end else begin
            pre_r   <= nrd_r;
            steps_r <= steps_r + SW'(1);
            st_r    <= S_RDN;
          end
        end
        S_FIX: begin
          nv_r[treq_r[TW-1:0]] <= 1'b0;
          if (tv_r[lv_r] && ti_r[lv_r] == treq_r[TW-1:0]) ti_r[lv_r] <= pre_r;
          st_r <= S_SRCH;
        end
        S_DROP: begin
          if (!hv_r[lv_r]) begin
            tv_r[lv_r]   <= 1'b0;
            ti_r[lv_r]   <= '0;
            mask_r[lv_r] <= 1'b0;
          end
          st_r <= S_SRCH;
        end
        S_SRCH: begin
          st_r <= S_OUT;
        end
        S_OUT: begin
          if (!res_v_r || out_ready) begin
            res_r.next_task  <= any ? 6'(hi_r[top]) : 6'd0;
            res_r.next_level <= any ? 5'(top) : 5'd0;
            res_r.any_ready  <= any;
            res_r.error      <= err_r;
            res_v_r <= 1'b1;
            st_r    <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_word)) else $error("result lost");
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_IDLE |-> (mask_r[0] == hv_r[0])) else $error("mask mismatch");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.error != 2'd3) else $error("bad error code");
`endif

endmodule

>>> src/priority_ready_list.sv
// ----------------------------------------------------------------------------
// priority_ready_list: hardware ready list with 32 priority levels
// Front queue takes words, engine applies list operations and reports top.
// ----------------------------------------------------------------------------
// channel | dir | payload   | handshake
// in_     | in  | prl_in_t  | in_valid / in_ready
// out_    | out | prl_out_t | out_valid / out_ready
// Add and query pass the idle, search and output states; a pop or a head
// remove adds link read and drop; a remove past the head alternates link
// read and walk per entry, then a link fix. The input queue registers words.
// Reset is synchronous; after it task 0 alone sits at level 0.
// A two-word queue lets input words arrive while a result waits.
module priority_ready_list #(
  parameter int TASKS  = 64,
  parameter int LEVELS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  prl_pkg::prl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output prl_pkg::prl_out_t out_data
);
  import prl_pkg::*;

  logic    q_valid, q_ready;
  prl_in_t q_data;

  prl_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  prl_engine #(.TASKS(TASKS), .LEVELS(LEVELS)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_data)
  );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the priority ready list
// Drives list operations over valid/ready, predicts the top ready task and
// error code of every word, and compares each result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import prl_pkg::*;

  localparam int TASKS  = 64;
  localparam int LEVELS = 32;
  localparam int CYCLE_LIMIT = 2000000;

  // Software copy of the ready list plus the queue of expected result words.
  class ready_list_board;
    bit        head_v[LEVELS];
    bit [5:0]  head_i[LEVELS];
    bit        tail_v[LEVELS];
    bit [5:0]  tail_i[LEVELS];
    bit        link_v[TASKS];
    bit [5:0]  link_i[TASKS];
    bit [31:0] mask;
    prl_out_t  pending[$];
    int        fails;
    int        checked;

    function void clear();
      for (int i = 0; i < LEVELS; i++) begin
        head_v[i] = 0; head_i[i] = 0; tail_v[i] = 0; tail_i[i] = 0;
      end
      for (int i = 0; i < TASKS; i++) begin
        link_v[i] = 0; link_i[i] = 0;
      end
      head_v[0] = 1;
      tail_v[0] = 1;
      mask = 32'd1;
      pending.delete();
    endfunction

    function void empty_check(int lv);
      if (!head_v[lv]) begin
        tail_v[lv] = 0;
        tail_i[lv] = 0;
        mask[lv] = 1'b0;
      end
    endfunction

    function logic [1:0] pop_head(int lv);
      bit [5:0] h;
      if (!head_v[lv]) return ERR_EMPTY;
      h = head_i[lv];
      head_v[lv] = link_v[h];
      head_i[lv] = link_i[h];
      link_v[h] = 0;
      link_i[h] = 0;
      empty_check(lv);
      return ERR_OK;
    endfunction

    function logic [1:0] unlink(int lv, bit [5:0] t);
      bit [5:0] prev;
      bit [5:0] cur;
      int steps;
      if (!head_v[lv]) return ERR_EMPTY;
      prev = head_i[lv];
      if (prev == t) begin
        head_v[lv] = link_v[t];
        head_i[lv] = link_i[t];
      end else begin
        steps = 0;
        forever begin
          if (!link_v[prev] || steps >= TASKS) return ERR_NOTFOUND;
          cur = link_i[prev];
          if (cur == t) break;
          prev = cur;
          steps++;
        end
        link_v[prev] = link_v[t];
        link_i[prev] = link_i[t];
      end
      link_v[t] = 0;
      link_i[t] = 0;
      if (!head_v[lv]) empty_check(lv);
      else if (tail_v[lv] && tail_i[lv] == t) tail_i[lv] = prev;
      return ERR_OK;
    endfunction

    function void note_word(prl_in_t w);
      prl_out_t r;
      logic [1:0] err;
      int lv;
      lv = w.level;
      err = ERR_OK;
      case (w.mode)
        MODE_ADD: begin
          if (!head_v[lv]) begin
            tail_v[lv] = 1;
            tail_i[lv] = w.task_req;
            mask[lv] = 1'b1;
          end
          link_v[w.task_req] = head_v[lv];
          link_i[w.task_req] = head_i[lv];
          head_v[lv] = 1;
          head_i[lv] = w.task_req;
        end
        MODE_POP:    err = pop_head(lv);
        MODE_REMOVE: err = unlink(lv, w.task_req);
        default:     err = ERR_OK;
      endcase
      r = '0;
      r.error = err;
      for (int i = 0; i < LEVELS; i++) begin
        if (mask[i]) begin
          r.next_level = 5'(i);
          r.any_ready = 1'b1;
        end
      end
      if (r.any_ready) r.next_task = head_i[r.next_level];
      pending.push_back(r);
    endfunction

    function void check_word(prl_out_t a);
      prl_out_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %p", a);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (a.next_task !== e.next_task) begin
        $error("next_task expected %0d actual %0d", e.next_task, a.next_task); fails++;
      end
      if (a.next_level !== e.next_level) begin
        $error("next_level expected %0d actual %0d", e.next_level, a.next_level); fails++;
      end
      if (a.any_ready !== e.any_ready) begin
        $error("any_ready expected %0d actual %0d", e.any_ready, a.any_ready); fails++;
      end
      if (a.error !== e.error) begin
        $error("error expected %0d actual %0d", e.error, a.error); fails++;
      end
    endfunction
  endclass

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_valid = 0;
  logic     in_ready;
  prl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 0;
  prl_out_t out_data;

  ready_list_board board;
  int send_idle = 0;
  int recv_stall = 0;
  int cycles = 0;
  int sent = 0;

  priority_ready_list dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Receiver: stall at random, check each accepted word.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[priority_ready_list] ERROR");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) board.check_word(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Idle at random before the word, then hold valid until accepted.
  task automatic send_word(prl_in_t w);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
    sent++;
  endtask

  task automatic send_op(logic [1:0] m, int t, int lv);
    prl_in_t w;
    w.mode = m;
    w.task_req = 6'(t);
    w.level = 5'(lv);
    send_word(w);
  endtask

  // Mostly legal traffic: adds of tasks not yet listed, removes of listed
  // ones, pops and queries at random levels, with some noise on top.
  task automatic random_word(ref bit [4:0] where[TASKS], ref bit listed[TASKS]);
    int t;
    int pick;
    pick = $urandom_range(99);
    t = $urandom_range(TASKS - 1);
    if (pick < 35) begin
      if (listed[t]) send_op(MODE_REMOVE, t, where[t]);
      else begin
        where[t] = 5'($urandom_range(LEVELS - 1));
        send_op(MODE_ADD, t, where[t]);
      end
      listed[t] = !listed[t];
    end else if (pick < 60) begin
      if (listed[t]) begin
        send_op(MODE_REMOVE, t, where[t]);
        listed[t] = 0;
      end else send_op(MODE_REMOVE, t, $urandom_range(LEVELS - 1));
    end else if (pick < 75) begin
      send_op(MODE_POP, $urandom_range(TASKS - 1), $urandom_range(LEVELS - 1));
      for (int i = 0; i < TASKS; i++) listed[i] = 0;
      // the pop makes the shadow bookkeeping unreliable; resync from board
      for (int lv = 0; lv < LEVELS; lv++) begin
        if (board.head_v[lv]) begin
          t = board.head_i[lv];
          for (int s = 0; s < TASKS; s++) begin
            listed[t] = 1;
            where[t] = 5'(lv);
            if (!board.link_v[t]) break;
            t = board.link_i[t];
          end
        end
      end
    end else if (pick < 85) begin
      send_op(MODE_QUERY, $urandom_range(TASKS - 1), $urandom_range(LEVELS - 1));
    end else begin
      send_op(2'($urandom_range(3)), t, $urandom_range(LEVELS - 1));
    end
  endtask

  initial begin
    bit [4:0] where[TASKS];
    bit       listed[TASKS];
    board = new();
    board.clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: query, extremes, empty levels, missing tasks, duplicates.
    send_op(MODE_QUERY, 63, 31);
    send_op(MODE_POP, 5, 31);
    send_op(MODE_REMOVE, 7, 17);
    send_op(MODE_ADD, 63, 31);
    send_op(MODE_ADD, 0, 31);
    send_op(MODE_ADD, 42, 31);
    send_op(MODE_REMOVE, 21, 31);
    send_op(MODE_REMOVE, 0, 31);
    send_op(MODE_REMOVE, 63, 31);
    send_op(MODE_POP, 13, 31);
    send_op(MODE_POP, 0, 31);
    send_op(MODE_POP, 0, 0);
    send_op(MODE_QUERY, 0, 0);
    send_op(MODE_ADD, 21, 10);
    send_op(MODE_ADD, 21, 10);
    send_op(MODE_REMOVE, 9, 10);
    send_op(MODE_REMOVE, 21, 10);
    send_op(MODE_ADD, 0, 0);
    send_op(MODE_ADD, 1, 0);
    send_op(MODE_ADD, 2, 0);
    send_op(MODE_REMOVE, 0, 0);
    send_op(MODE_REMOVE, 1, 0);

    for (int i = 0; i < TASKS; i++) listed[i] = 0;
    for (int lv = 0; lv < LEVELS; lv++) begin
      int t;
      if (board.head_v[lv]) begin
        t = board.head_i[lv];
        for (int s = 0; s < TASKS; s++) begin
          listed[t] = 1;
          where[t] = 5'(lv);
          if (!board.link_v[t]) break;
          t = board.link_i[t];
        end
      end
    end

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        3: begin send_idle = 19; recv_stall = 19; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      repeat (90) random_word(where, listed);
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d words over four idle/stall mixes; checked %0d results.",
             sent, board.checked);
    if (board.fails == 0 && board.pending.size() == 0)
      $display("[priority_ready_list] OK");
    else
      $display("[priority_ready_list] ERROR");
    $finish;
  end

endmodule
